>>> src/lrfifo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfifo_pkg
// Types, codes and the terminator matcher shared by the receive FIFO modules.
// ----------------------------------------------------------------------------
package lrfifo_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 64;
	localparam logic [3:0]  MAX_TERM_LEN   = 4'd10;

	localparam logic [1:0] OP_RECEIVE = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;

	localparam logic [1:0] CFG_TERM_LOW  = 2'd0;
	localparam logic [1:0] CFG_TERM_HIGH = 2'd1;
	localparam logic [1:0] CFG_TERM_LEN  = 2'd2;

	localparam logic [63:0] TERM_LOW_RST  = 64'h0000_0000_0000_0A0D;
	localparam logic [15:0] TERM_HIGH_RST = 16'h0000;
	localparam logic [3:0]  TERM_LEN_RST  = 4'd2;

	localparam logic [7:0]  EMPTY_BYTE = 8'hFF;
	localparam logic [15:0] LINE_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] line_byte;
		logic       frame_error;
		logic       parity_error;
		logic       overrun_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        read_empty;
		logic        line_end;
		logic        byte_dropped;
		logic [6:0]  bytes_available;
		logic [15:0] lines_available;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_RECV,
		CMD_REJECT,
		CMD_READ,
		CMD_FLUSH,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [3:0] idx;
		logic       hit;
	} match_t;

	// A mismatching byte restarts the matcher at index one when it equals the
	// first terminator byte, otherwise at zero.
	function automatic match_t lrfifo_match(input logic [3:0] idx, input logic [7:0] b,
			input logic [15:0][7:0] term, input logic [3:0] len);
		match_t     r;
		logic [3:0] cur;
		r.idx = idx;
		r.hit = 1'b0;
		cur   = (idx >= len) ? 4'd0 : idx;
		if (len != 4'd0) begin
			if (term[cur] == b) begin
				if ((cur + 4'd1) == len) begin
					r.idx = 4'd0;
					r.hit = 1'b1;
				end else begin
					r.idx = cur + 4'd1;
				end
			end else begin
				r.idx = (b == term[0]) ? 4'd1 : 4'd0;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/lrfifo_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfifo_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lrfifo_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/lrfifo_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfifo_front
// Accepts operations, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lrfifo_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire lrfifo_pkg::in_item_t  cmd,
	output logic                       deq_valid,
	input  wire logic                  deq_ready,
	output lrfifo_pkg::cmd_t           deq_cmd
);

	import lrfifo_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.data = cmd.line_byte;
		unique case (cmd.op)
			OP_RECEIVE: begin
				cls.kind = (cmd.frame_error | cmd.parity_error | cmd.overrun_error)
					? CMD_REJECT : CMD_RECV;
			end
			OP_READ:  cls.kind = CMD_READ;
			OP_FLUSH: cls.kind = CMD_FLUSH;
			default:  cls.kind = CMD_NOP;
		endcase
	end

	assign cmd_ready = (cnt_q != 2'd2);
	assign push      = cmd_valid & cmd_ready;
	assign deq_valid = (cnt_q != 2'd0);
	assign pop       = deq_valid & deq_ready;
	assign deq_cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/lrfifo_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrfifo_back
// Executes queued operations on the byte store, matchers and line count.
// ----------------------------------------------------------------------------
module lrfifo_back #(
	parameter int unsigned FIFO_DEPTH = lrfifo_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire lrfifo_pkg::cmd_t      cmd,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [63:0]           cfg_wdata,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output lrfifo_pkg::out_item_t      rsp
);

	import lrfifo_pkg::*;

	localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FIFO_DEPTH);

	typedef enum logic {
		ST_RUN,
		ST_READ_WAIT
	} state_t;

	state_t           state_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [3:0]       rx_idx_q;
	logic [3:0]       rd_idx_q;
	logic [15:0]      lines_q;
	logic [63:0]      term_low_q;
	logic [15:0]      term_high_q;
	logic [3:0]       term_len_q;
	logic             rsp_valid_q;
	out_item_t        rsp_q;

	logic [15:0][7:0] term;
	logic [3:0]       act_len;
	logic [7:0]       ram_rdata;
	logic             out_free;
	logic             take;
	logic             full;
	logic             ram_we;
	logic             ram_re;
	match_t           rx_m;
	match_t           rd_m;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_nxt;

	assign term     = {48'h0, term_high_q, term_low_q};
	assign act_len  = (term_len_q > MAX_TERM_LEN) ? MAX_TERM_LEN : term_len_q;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_RUN) && out_free && !cfg_we;
	assign take     = cmd_valid && cmd_ready;
	assign full     = (fill_q == FILL_MAX);
	assign ram_we   = take && (cmd.kind == CMD_RECV) && !full;
	assign ram_re   = take && (cmd.kind == CMD_READ) && (fill_q != '0);
	assign rx_m     = lrfifo_match(rx_idx_q, cmd.data, term, act_len);
	assign rd_m     = lrfifo_match(rd_idx_q, ram_rdata, term, act_len);
	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lrfifo_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (cmd.data),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			fill_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rx_idx_q    <= 4'd0;
			rd_idx_q    <= 4'd0;
			lines_q     <= 16'd0;
			term_low_q  <= TERM_LOW_RST;
			term_high_q <= TERM_HIGH_RST;
			term_len_q  <= TERM_LEN_RST;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_TERM_LOW || cfg_index == CFG_TERM_HIGH
						|| cfg_index == CFG_TERM_LEN) begin
					unique case (cfg_index)
						CFG_TERM_LOW:  term_low_q  <= cfg_wdata;
						CFG_TERM_HIGH: term_high_q <= cfg_wdata[15:0];
						default:       term_len_q  <= cfg_wdata[3:0];
					endcase
					fill_q   <= '0;
					head_q   <= '0;
					tail_q   <= '0;
					rx_idx_q <= 4'd0;
					rd_idx_q <= 4'd0;
					lines_q  <= 16'd0;
				end
			end else if (state_q == ST_READ_WAIT) begin
				rd_idx_q              <= rd_m.idx;
				rsp_valid_q           <= 1'b1;
				rsp_q                 <= '0;
				rsp_q.read_byte       <= ram_rdata;
				rsp_q.line_end        <= rd_m.hit;
				rsp_q.bytes_available <= 7'(fill_q);
				if (rd_m.hit && lines_q != 16'd0) begin
					lines_q               <= lines_q - 16'd1;
					rsp_q.lines_available <= lines_q - 16'd1;
				end else begin
					rsp_q.lines_available <= lines_q;
				end
				state_q <= ST_RUN;
			end else if (take) begin
				rsp_q                 <= '0;
				rsp_q.bytes_available <= 7'(fill_q);
				rsp_q.lines_available <= lines_q;
				rsp_valid_q           <= 1'b1;
				unique case (cmd.kind)
					CMD_RECV: begin
						rsp_q.byte_dropped <= full;
						if (!full) begin
							tail_q                <= tail_nxt;
							fill_q                <= fill_q + FILL_W'(1);
							rsp_q.bytes_available <= 7'(fill_q + FILL_W'(1));
						end
						rx_idx_q <= rx_m.idx;
						if (rx_m.hit && lines_q != LINE_MAX) begin
							lines_q               <= lines_q + 16'd1;
							rsp_q.lines_available <= lines_q + 16'd1;
						end
					end
					CMD_REJECT: begin
						rsp_q.byte_dropped <= 1'b1;
					end
					CMD_READ: begin
						if (fill_q == '0) begin
							rsp_q.read_byte       <= EMPTY_BYTE;
							rsp_q.read_empty      <= 1'b1;
							rsp_q.lines_available <= 16'd0;
							lines_q               <= 16'd0;
						end else begin
							head_q      <= head_nxt;
							fill_q      <= fill_q - FILL_W'(1);
							rsp_valid_q <= 1'b0;
							state_q     <= ST_READ_WAIT;
						end
					end
					CMD_FLUSH: begin
						fill_q                <= '0;
						head_q                <= '0;
						tail_q                <= '0;
						rx_idx_q              <= 4'd0;
						rd_idx_q              <= 4'd0;
						lines_q               <= 16'd0;
						rsp_q.bytes_available <= 7'd0;
						rsp_q.lines_available <= 16'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> src/line_aware_receive_fifo_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_aware_receive_fifo_top
// Receive byte FIFO of a serial port that counts lines ended by a
// programmable terminator sequence.
// ----------------------------------------------------------------------------
// Operations enter a two-entry queue and are executed one at a time by the
// back end, each giving one result transfer. A receive, a rejected byte, a
// flush or an unused code is done in the back end's run state; a read of a
// stored byte also passes the read-wait state, for the registered read port
// of the byte memory. The byte memory has no clearing pass after reset.
// Writing any terminator register also flushes FIFO, matchers, line count.
module line_aware_receive_fifo_top #(
	parameter int unsigned FIFO_DEPTH = lrfifo_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire lrfifo_pkg::in_item_t  cmd,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output lrfifo_pkg::out_item_t      rsp,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [63:0]           cfg_wdata
);

	import lrfifo_pkg::*;

	logic deq_valid;
	logic deq_ready;
	cmd_t deq_cmd;

	lrfifo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_cmd   (deq_cmd)
	);

	lrfifo_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (deq_valid),
		.cmd_ready (deq_ready),
		.cmd       (deq_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
